[src/srgbg2ab_pkg.sv]
// types, constants and arithmetic helpers for the gamma-2 alpha blend pipeline
package srgbg2ab_pkg;

	localparam int unsigned FRAC_W = 17;
	localparam int unsigned SUM_W  = FRAC_W + 1;
	localparam int unsigned NCH    = 3;

	typedef logic [FRAC_W-1:0] frac_t;
	typedef logic [SUM_W-1:0]  sum_t;
	typedef logic [7:0]        byte_t;

	localparam frac_t FRAC_ONE  = frac_t'(65536);
	localparam int unsigned FRAC_HALF = 32768;

	typedef enum logic [1:0] {
		CFG_FILL_RED   = 2'd0,
		CFG_FILL_GREEN = 2'd1,
		CFG_FILL_BLUE  = 2'd2,
		CFG_FILL_ALPHA = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		ACT_FILL   = 1'b0,
		ACT_BITMAP = 1'b1
	} action_t;

	typedef frac_t edge_tab_t [256];

	// c/255 rounded to nearest, equals c*257 plus one for c >= 128
	function automatic frac_t byte_to_frac(byte_t c);
		return frac_t'({c, c}) + frac_t'(c[7]);
	endfunction

	// product of two fractions, rounded half up
	function automatic frac_t frac_mul(frac_t x, frac_t y);
		logic [2*FRAC_W-1:0] p;
		p = (2*FRAC_W)'(x) * (2*FRAC_W)'(y) + (2*FRAC_W)'(FRAC_HALF);
		return p[FRAC_W+15:16];
	endfunction

	// alpha fraction to byte, rounded half up, saturated
	function automatic byte_t alpha_to_byte(frac_t a);
		logic [25:0] t;
		t = {1'b0, a, 8'h00} - 26'(a) + 26'(FRAC_HALF);
		return (t[25:16] > 10'd255) ? 8'hff : t[23:16];
	endfunction

	// smallest v for which result bit pattern t is reached by the root search
	function automatic edge_tab_t build_edges();
		edge_tab_t tab;
		longint e;
		tab[0] = '0;
		for (int t = 1; t < 256; t++) begin
			e = longint'(2*t - 1) * longint'(2*t - 1) * 64'sd16384;
			tab[t] = frac_t'((e + 64'sd65024) / 64'sd65025);
		end
		return tab;
	endfunction

	localparam edge_tab_t SQRT_EDGE = build_edges();

	// one bit of the root search: round half up of 255*sqrt(v/65536)
	function automatic byte_t sqrt_step(frac_t v, byte_t res, int unsigned bpos);
		byte_t t;
		t = res | byte_t'(1 << bpos);
		return (v >= SQRT_EDGE[t]) ? t : res;
	endfunction

endpackage

[src/srgb_gamma2_alpha_blend_top.sv]
// gamma-2 premultiplied alpha over blend of one ARGB8888 pixel per beat
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid in_ready action dest_pixel  | input
//          | source_pixel                         |
//  out     | out_valid out_ready blended_pixel    | output
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data | input
//
// nine register stages: byte to fraction, squaring, source and alpha products,
// over blend, saturation, then four stages of two root search bits each.
// one pixel per clock sustained while out_ready stays high.
// every stage holds its own valid bit; a stage takes new data when empty or
// when the stage after it moves, so bubbles close up during an output stall.
// arst_n clears the valid bits and sets the fill registers to their defaults.
module srgb_gamma2_alpha_blend_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [31:0] dest_pixel,
	input  logic [31:0] source_pixel,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] blended_pixel,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int unsigned NS = 9;
	localparam int unsigned NCH = srgbg2ab_pkg::NCH;

	// configuration
	srgbg2ab_pkg::byte_t fill_q [NCH];
	srgbg2ab_pkg::byte_t fill_alpha_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) fill_q[i] <= '0;
			fill_alpha_q <= 8'hff;
		end else if (cfg_valid && cfg_ready) begin
			case (srgbg2ab_pkg::cfg_idx_t'(cfg_index))
				srgbg2ab_pkg::CFG_FILL_RED:   fill_q[0] <= cfg_data;
				srgbg2ab_pkg::CFG_FILL_GREEN: fill_q[1] <= cfg_data;
				srgbg2ab_pkg::CFG_FILL_BLUE:  fill_q[2] <= cfg_data;
				srgbg2ab_pkg::CFG_FILL_ALPHA: fill_alpha_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline flow control
	logic [NS:1]   stg_vld_q;
	logic [NS+1:1] adv;

	always_comb begin
		adv[NS+1] = out_ready;
		for (int k = NS; k >= 1; k--) adv[k] = !stg_vld_q[k] || adv[k+1];
	end

	assign in_ready  = adv[1];
	assign out_valid = stg_vld_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q <= '0;
		end else begin
			if (adv[1]) stg_vld_q[1] <= in_valid;
			for (int k = 2; k <= NS; k++) begin
				if (adv[k]) stg_vld_q[k] <= stg_vld_q[k-1];
			end
		end
	end

	// stage 1: bytes to fractions
	logic                        act_s1;
	srgbg2ab_pkg::frac_t         qd_s1 [NCH];
	srgbg2ab_pkg::frac_t         qs_s1 [NCH];
	srgbg2ab_pkg::frac_t         qda_s1, qsa_s1, ca_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			act_s1 <= action;
			for (int i = 0; i < NCH; i++) begin
				qd_s1[i] <= srgbg2ab_pkg::byte_to_frac(dest_pixel[16-8*i +: 8]);
				qs_s1[i] <= (action == srgbg2ab_pkg::ACT_BITMAP)
					? srgbg2ab_pkg::byte_to_frac(source_pixel[16-8*i +: 8])
					: srgbg2ab_pkg::byte_to_frac(fill_q[i]);
			end
			qda_s1 <= srgbg2ab_pkg::byte_to_frac(dest_pixel[31:24]);
			qsa_s1 <= srgbg2ab_pkg::byte_to_frac(source_pixel[31:24]);
			ca_s1  <= srgbg2ab_pkg::byte_to_frac(fill_alpha_q);
		end
	end

	// stage 2: linear light and source alpha
	srgbg2ab_pkg::frac_t dc_s2 [NCH];
	srgbg2ab_pkg::frac_t sl_s2 [NCH];
	srgbg2ab_pkg::frac_t sa_s2, da_s2, ca_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int i = 0; i < NCH; i++) begin
				dc_s2[i] <= srgbg2ab_pkg::frac_mul(qd_s1[i], qd_s1[i]);
				sl_s2[i] <= (act_s1 == srgbg2ab_pkg::ACT_BITMAP)
					? srgbg2ab_pkg::frac_mul(qs_s1[i], qs_s1[i]) : qs_s1[i];
			end
			sa_s2 <= (act_s1 == srgbg2ab_pkg::ACT_BITMAP)
				? srgbg2ab_pkg::frac_mul(qsa_s1, ca_s1) : ca_s1;
			da_s2 <= qda_s1;
			ca_s2 <= ca_s1;
		end
	end

	// stage 3: premultiplied source and alpha product
	srgbg2ab_pkg::frac_t dc_s3 [NCH];
	srgbg2ab_pkg::frac_t sc_s3 [NCH];
	srgbg2ab_pkg::frac_t inv_s3, sa_s3, da_s3, mda_s3;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int i = 0; i < NCH; i++) begin
				dc_s3[i] <= dc_s2[i];
				sc_s3[i] <= srgbg2ab_pkg::frac_mul(sl_s2[i], ca_s2);
			end
			inv_s3 <= srgbg2ab_pkg::FRAC_ONE - sa_s2;
			sa_s3  <= sa_s2;
			da_s3  <= da_s2;
			mda_s3 <= srgbg2ab_pkg::frac_mul(da_s2, sa_s2);
		end
	end

	// stage 4: over blend
	srgbg2ab_pkg::sum_t  c_s4 [NCH];
	srgbg2ab_pkg::frac_t ba_s4;
	srgbg2ab_pkg::sum_t  ba_sum;

	assign ba_sum = srgbg2ab_pkg::sum_t'(sa_s3) + srgbg2ab_pkg::sum_t'(da_s3)
		- srgbg2ab_pkg::sum_t'(mda_s3);

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			for (int i = 0; i < NCH; i++) begin
				c_s4[i] <= srgbg2ab_pkg::sum_t'(srgbg2ab_pkg::frac_mul(inv_s3, dc_s3[i]))
					+ srgbg2ab_pkg::sum_t'(sc_s3[i]);
			end
			ba_s4 <= ba_sum[srgbg2ab_pkg::FRAC_W-1:0];
		end
	end

	// stage 5: saturate colour, alpha back to byte
	srgbg2ab_pkg::frac_t v_s5 [NCH];
	srgbg2ab_pkg::byte_t a_s5;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			for (int i = 0; i < NCH; i++) begin
				v_s5[i] <= (c_s4[i] > srgbg2ab_pkg::sum_t'(srgbg2ab_pkg::FRAC_ONE))
					? srgbg2ab_pkg::FRAC_ONE : c_s4[i][srgbg2ab_pkg::FRAC_W-1:0];
			end
			a_s5 <= srgbg2ab_pkg::alpha_to_byte(ba_s4);
		end
	end

	// stages 6 to 9: root search, two bits per stage
	srgbg2ab_pkg::frac_t v_s6 [NCH];
	srgbg2ab_pkg::frac_t v_s7 [NCH];
	srgbg2ab_pkg::frac_t v_s8 [NCH];
	srgbg2ab_pkg::byte_t r_s6 [NCH];
	srgbg2ab_pkg::byte_t r_s7 [NCH];
	srgbg2ab_pkg::byte_t r_s8 [NCH];
	srgbg2ab_pkg::byte_t r_s9 [NCH];
	srgbg2ab_pkg::byte_t a_s6, a_s7, a_s8, a_s9;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			for (int i = 0; i < NCH; i++) begin
				v_s6[i] <= v_s5[i];
				r_s6[i] <= srgbg2ab_pkg::sqrt_step(v_s5[i],
					srgbg2ab_pkg::sqrt_step(v_s5[i], '0, 7), 6);
			end
			a_s6 <= a_s5;
		end
		if (adv[7]) begin
			for (int i = 0; i < NCH; i++) begin
				v_s7[i] <= v_s6[i];
				r_s7[i] <= srgbg2ab_pkg::sqrt_step(v_s6[i],
					srgbg2ab_pkg::sqrt_step(v_s6[i], r_s6[i], 5), 4);
			end
			a_s7 <= a_s6;
		end
		if (adv[8]) begin
			for (int i = 0; i < NCH; i++) begin
				v_s8[i] <= v_s7[i];
				r_s8[i] <= srgbg2ab_pkg::sqrt_step(v_s7[i],
					srgbg2ab_pkg::sqrt_step(v_s7[i], r_s7[i], 3), 2);
			end
			a_s8 <= a_s7;
		end
		if (adv[9]) begin
			for (int i = 0; i < NCH; i++) begin
				r_s9[i] <= srgbg2ab_pkg::sqrt_step(v_s8[i],
					srgbg2ab_pkg::sqrt_step(v_s8[i], r_s8[i], 1), 0);
			end
			a_s9 <= a_s8;
		end
	end

	assign blended_pixel = {a_s9, r_s9[0], r_s9[1], r_s9[2]};

endmodule
